/* rtl/core/assert_macros.svh */
// Assertion macros for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`endif

/* rtl/core/amf_pkg.sv */
package amf_pkg;

    localparam int NUM_STAGES_DEF     = 10;
    localparam int COS_TABLE_SIZE_DEF = 512;
    localparam int COEF_ROWS          = 10;
    localparam int COEF_TAPS          = 5;

    localparam logic [30:0] PHASE_STEP_RESET = 31'h1000_0000;
    localparam logic [30:0] QUARTER_TURN     = 31'h2000_0000;
    localparam logic [63:0] Q62_ONE          = 64'h4000_0000_0000_0000;
    localparam logic [63:0] Q62_HALF_PI      = 64'h6487_ED51_10B4_611A;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LO_POS,
        ST_LO_IDX,
        ST_LO_A,
        ST_LO_B,
        ST_LO_SUM,
        ST_MIX_I,
        ST_MIX_Q,
        ST_MIX_END,
        ST_BQ,
        ST_EN_I,
        ST_EN_Q,
        ST_EN_SUM,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_OUT
    } state_t;

    localparam logic [31:0] COEF_ROM [COEF_ROWS][COEF_TAPS] = '{
        '{32'h0005936a, 32'h0003f815, 32'h0005936a, 32'h7226b94b, 32'hcb873df5},
        '{32'h40000000, 32'hbacbbbfa, 32'h40000000, 32'h6dfdc5c1, 32'hc903ae47},
        '{32'h40000000, 32'ha2d9c8e8, 32'h3fffffff, 32'h6b7021ab, 32'hc4e7e0fa},
        '{32'h40000000, 32'h80001f6b, 32'h40000000, 32'h7d6d2440, 32'hc279b074},
        '{32'h40000000, 32'h9c07aaa8, 32'h40000000, 32'h6a236c85, 32'hc22b4d79},
        '{32'h40000000, 32'h99ed4b45, 32'h3fffffff, 32'h69f450f6, 32'hc098a5bc},
        '{32'h40000000, 32'h8000ddd1, 32'h3fffffff, 32'h7f7792a0, 32'hc081e091},
        '{32'h40000000, 32'h8001a3a8, 32'h40000000, 32'h7fd37b91, 32'hc028b7e5},
        '{32'h40000000, 32'h800219dd, 32'h40000000, 32'h7feea1fb, 32'hc00e535c},
        '{32'h40000000, 32'h80024ada, 32'h40000000, 32'h7ff992bf, 32'hc0039ddb}
    };

    // stages past the table pass their input through
    function automatic logic [31:0] coef(input logic [3:0] row, input logic [2:0] tap);
        logic [31:0] v;
        if (int'(tap) >= COEF_TAPS) begin
            v = 32'd0;
        end else if (int'(row) < COEF_ROWS) begin
            v = COEF_ROM[row][tap];
        end else begin
            v = (tap == 3'd0) ? 32'h4000_0000 : 32'd0;
        end
        return v;
    endfunction

    function automatic logic [63:0] mul62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] series_div(input logic [63:0] t, input logic odd,
                                               input logic [3:0] k);
        logic [63:0] q;
        case ({odd, k})
            {1'b0, 4'd1}:  q = t / 64'd2;
            {1'b0, 4'd2}:  q = t / 64'd12;
            {1'b0, 4'd3}:  q = t / 64'd30;
            {1'b0, 4'd4}:  q = t / 64'd56;
            {1'b0, 4'd5}:  q = t / 64'd90;
            {1'b0, 4'd6}:  q = t / 64'd132;
            {1'b0, 4'd7}:  q = t / 64'd182;
            {1'b0, 4'd8}:  q = t / 64'd240;
            {1'b0, 4'd9}:  q = t / 64'd306;
            {1'b0, 4'd10}: q = t / 64'd380;
            {1'b0, 4'd11}: q = t / 64'd462;
            {1'b0, 4'd12}: q = t / 64'd552;
            {1'b0, 4'd13}: q = t / 64'd650;
            {1'b1, 4'd1}:  q = t / 64'd6;
            {1'b1, 4'd2}:  q = t / 64'd20;
            {1'b1, 4'd3}:  q = t / 64'd42;
            {1'b1, 4'd4}:  q = t / 64'd72;
            {1'b1, 4'd5}:  q = t / 64'd110;
            {1'b1, 4'd6}:  q = t / 64'd156;
            {1'b1, 4'd7}:  q = t / 64'd210;
            {1'b1, 4'd8}:  q = t / 64'd272;
            {1'b1, 4'd9}:  q = t / 64'd342;
            {1'b1, 4'd10}: q = t / 64'd420;
            {1'b1, 4'd11}: q = t / 64'd506;
            {1'b1, 4'd12}: q = t / 64'd600;
            {1'b1, 4'd13}: q = t / 64'd702;
            default:       q = t;
        endcase
        return q;
    endfunction

    // Taylor series in Q62: sine when odd is set, cosine otherwise
    function automatic logic [63:0] series(input logic [63:0] x, input logic odd);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mul62(x, x);
        term = odd ? x : Q62_ONE;
        sum  = term;
        for (int k = 1; k <= 13; k++) begin
            term = series_div(mul62(term, x2), odd, 4'(k));
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [31:0] wave_value(input logic [63:0] ang, input logic [1:0] quad);
        logic [63:0] s;
        logic [63:0] mag;
        logic [31:0] v;
        s   = series(ang, ~quad[0]);
        mag = (s + 64'h4000_0000) >> 31;
        if (mag > 64'h8000_0000) begin
            mag = 64'h8000_0000;
        end
        if (!quad[1]) begin
            v = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end else begin
            v = 32'd0 - mag[31:0];
        end
        return v;
    endfunction

endpackage

/* rtl/core/amf_ram.sv */
module amf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8 * amf_pkg::NUM_STAGES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/amf_wave_rom.sv */
module amf_wave_rom #(
    parameter int COS_TABLE_SIZE = amf_pkg::COS_TABLE_SIZE_DEF
) (
    input  logic                                aclk,
    input  logic [$clog2(COS_TABLE_SIZE+1)-1:0] addr,
    output logic [31:0]                         rdata
);

    localparam logic [63:0] Nw = 64'(COS_TABLE_SIZE);

    logic [31:0] tbl [COS_TABLE_SIZE+1];
    logic [31:0] rdata_reg;

    for (genvar k = 0; k <= COS_TABLE_SIZE; k++) begin : g_entry
        localparam logic [63:0] U    = 64'(4 * k);
        localparam logic [63:0] Quad = (U / Nw) % 64'd4;
        localparam logic [63:0] Rem  = U % Nw;
        localparam logic [63:0] Ang  = (amf_pkg::Q62_HALF_PI / Nw) * Rem
                                     + ((amf_pkg::Q62_HALF_PI % Nw) * Rem) / Nw;
        localparam logic [31:0] Value = amf_pkg::wave_value(Ang, Quad[1:0]);
        assign tbl[k] = Value;
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= tbl[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/amf_mul.sv */
module amf_mul (
    input  logic               aclk,
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    output logic signed [65:0] product
);

    logic signed [65:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

/* rtl/core/amf_sqrt.sv */
module amf_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [61:0] radicand,
    output logic        done,
    output logic [30:0] root
);

    logic [61:0] rem_reg;
    logic [61:0] res_reg;
    logic [61:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [61:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && bit_reg[0];
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // one result bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= radicand;
            res_reg <= 62'd0;
            bit_reg <= {2'b01, 60'd0};
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[30:0];

endmodule

/* rtl/core/am_iq_mix_filter_magnitude_unit.sv */
// One I/Q pair in, one envelope out; a single 33x33 multiplier is shared by the LO, mix, biquad and envelope steps.
// A new I/Q pair is accepted only in the idle state, so one item is in flight at a time; the biquad
// MACs for each stage and channel and the 31-step square root take most of that time.
// Reset (aresetn low, synchronous) clears phase, filter history and phase_step to 0x10000000.
module am_iq_mix_filter_magnitude_unit #(
    parameter int NUM_STAGES     = amf_pkg::NUM_STAGES_DEF,
    parameter int COS_TABLE_SIZE = amf_pkg::COS_TABLE_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_i [31:0], sample_q [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // envelope [30:0], zero [31]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data   // phase_step
);

    localparam int HistDepth = 8 * NUM_STAGES;
    localparam int HAW       = $clog2(HistDepth);
    localparam int SW        = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int RAW       = $clog2(COS_TABLE_SIZE + 1);

    amf_pkg::state_t state_reg, state_next;

    logic [30:0]          phase_step_reg;
    logic [30:0]          phase_reg;
    logic [31:0]          si_reg, sq_reg;
    logic [30:0]          f_reg;
    logic [RAW-1:0]       idx_reg;
    logic [31:0]          t1_reg, lo_reg;
    logic [31:0]          x_cur_reg, xq_reg, yi_reg, yq_reg;
    logic [31:0]          h0_reg, h2_reg;
    logic [63:0]          acc_reg;
    logic [30:0]          e_reg;
    logic [HAW-1:0]       base_reg;
    logic [SW-1:0]        stage_reg;
    logic                 ch_reg;
    logic [2:0]           tap_reg;
    logic [HistDepth-1:0] hist_valid_reg;
    logic                 rvalid_reg;
    logic                 m_tvalid_reg;
    logic [30:0]          m_tdata_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [RAW-1:0]     rom_addr;
    logic [31:0]        rom_q;
    logic               hist_we;
    logic [HAW-1:0]     hist_waddr, hist_raddr;
    logic [31:0]        hist_wdata, hist_q, hq;
    logic               sq_start, sq_done;
    logic [30:0]        sq_root;
    logic [30:0]        lo_x;
    logic [31:0]        coef_cur, csum, y_val;
    logic [63:0]        acc_sum;
    logic               last_stage, out_free;

    function automatic logic [31:0] sat_q31(input logic signed [65:0] p);
        logic [31:0] hi;
        hi = p[63:32];
        return ($signed(hi) > 32'sh3FFF_FFFF) ? 32'h7FFF_FFFE : {hi[30:0], 1'b0};
    endfunction

    amf_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    amf_wave_rom #(.COS_TABLE_SIZE(COS_TABLE_SIZE)) u_rom (
        .aclk  (aclk),
        .addr  (rom_addr),
        .rdata (rom_q)
    );

    amf_ram #(.WIDTH(32), .DEPTH(HistDepth)) u_hist (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_q)
    );

    amf_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand ({e_reg, 31'd0}),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign lo_x       = phase_reg + amf_pkg::QUARTER_TURN;
    assign hq         = rvalid_reg ? hist_q : 32'd0;
    assign coef_cur   = amf_pkg::coef(4'(stage_reg), tap_reg);
    assign acc_sum    = acc_reg + prod[63:0];
    assign y_val      = acc_sum[61:30];
    assign csum       = t1_reg + prod[63:32];
    assign last_stage = (stage_reg == SW'(NUM_STAGES - 1));
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_tready  = (state_reg == amf_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, m_tdata_reg};

    always_comb begin
        state_next = state_reg;
        mul_a      = 33'sd0;
        mul_b      = 33'sd0;
        rom_addr   = idx_reg;
        hist_raddr = base_reg + HAW'(tap_reg[1:0]);
        hist_we    = 1'b0;
        hist_waddr = base_reg;
        hist_wdata = x_cur_reg;
        sq_start   = 1'b0;
        case (state_reg)
            amf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = amf_pkg::ST_LO_POS;
                end
            end
            amf_pkg::ST_LO_POS: begin
                mul_a      = {2'b00, lo_x};
                mul_b      = 33'(COS_TABLE_SIZE);
                state_next = amf_pkg::ST_LO_IDX;
            end
            amf_pkg::ST_LO_IDX: begin
                rom_addr   = prod[31 +: RAW];
                state_next = amf_pkg::ST_LO_A;
            end
            amf_pkg::ST_LO_A: begin
                rom_addr   = idx_reg + RAW'(1);
                mul_a      = 33'sh0_8000_0000 - {2'b00, f_reg};
                mul_b      = {rom_q[31], rom_q};
                state_next = amf_pkg::ST_LO_B;
            end
            amf_pkg::ST_LO_B: begin
                mul_a      = {2'b00, f_reg};
                mul_b      = {rom_q[31], rom_q};
                state_next = amf_pkg::ST_LO_SUM;
            end
            amf_pkg::ST_LO_SUM: begin
                state_next = amf_pkg::ST_MIX_I;
            end
            amf_pkg::ST_MIX_I: begin
                mul_a      = {si_reg[31], si_reg};
                mul_b      = {lo_reg[31], lo_reg};
                state_next = amf_pkg::ST_MIX_Q;
            end
            amf_pkg::ST_MIX_Q: begin
                mul_a      = {sq_reg[31], sq_reg};
                mul_b      = {lo_reg[31], lo_reg};
                state_next = amf_pkg::ST_MIX_END;
            end
            amf_pkg::ST_MIX_END: begin
                state_next = amf_pkg::ST_BQ;
            end
            amf_pkg::ST_BQ: begin
                mul_a = {coef_cur[31], coef_cur};
                mul_b = (tap_reg == 3'd0) ? {x_cur_reg[31], x_cur_reg} : {hq[31], hq};
                case (tap_reg)
                    3'd1: begin
                        hist_we = 1'b1;
                    end
                    3'd2: begin
                        hist_we    = 1'b1;
                        hist_waddr = base_reg + HAW'(1);
                        hist_wdata = h0_reg;
                    end
                    3'd4: begin
                        hist_we    = 1'b1;
                        hist_waddr = base_reg + HAW'(3);
                        hist_wdata = h2_reg;
                    end
                    3'd5: begin
                        hist_we    = 1'b1;
                        hist_waddr = base_reg + HAW'(2);
                        hist_wdata = y_val;
                        if (last_stage && ch_reg) begin
                            state_next = amf_pkg::ST_EN_I;
                        end
                    end
                    default: ;
                endcase
            end
            amf_pkg::ST_EN_I: begin
                mul_a      = {yi_reg[31], yi_reg};
                mul_b      = {yi_reg[31], yi_reg};
                state_next = amf_pkg::ST_EN_Q;
            end
            amf_pkg::ST_EN_Q: begin
                mul_a      = {yq_reg[31], yq_reg};
                mul_b      = {yq_reg[31], yq_reg};
                state_next = amf_pkg::ST_EN_SUM;
            end
            amf_pkg::ST_EN_SUM: begin
                state_next = amf_pkg::ST_SQRT_GO;
            end
            amf_pkg::ST_SQRT_GO: begin
                sq_start   = 1'b1;
                state_next = amf_pkg::ST_SQRT_WAIT;
            end
            amf_pkg::ST_SQRT_WAIT: begin
                if (sq_done) begin
                    state_next = amf_pkg::ST_OUT;
                end
            end
            amf_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = amf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = amf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= amf_pkg::ST_IDLE;
            phase_step_reg <= amf_pkg::PHASE_STEP_RESET;
            phase_reg      <= 31'd0;
            hist_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                phase_step_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                phase_reg <= phase_reg + phase_step_reg;
            end
            if (hist_we) begin
                hist_valid_reg[hist_waddr] <= 1'b1;
            end
            if (state_reg == amf_pkg::ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rvalid_reg <= hist_valid_reg[hist_raddr];
        case (state_reg)
            amf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    si_reg <= s_tdata[31:0];
                    sq_reg <= s_tdata[63:32];
                end
            end
            amf_pkg::ST_LO_IDX: begin
                f_reg   <= prod[30:0];
                idx_reg <= prod[31 +: RAW];
            end
            amf_pkg::ST_LO_B: begin
                t1_reg <= prod[63:32];
            end
            amf_pkg::ST_LO_SUM: begin
                lo_reg <= {csum[30:0], 1'b0};
            end
            amf_pkg::ST_MIX_Q: begin
                x_cur_reg <= sat_q31(prod);
            end
            amf_pkg::ST_MIX_END: begin
                xq_reg    <= sat_q31(prod);
                base_reg  <= '0;
                stage_reg <= '0;
                ch_reg    <= 1'b0;
                tap_reg   <= 3'd0;
            end
            amf_pkg::ST_BQ: begin
                if (tap_reg == 3'd1) begin
                    h0_reg  <= hq;
                    acc_reg <= prod[63:0];
                end else if (tap_reg != 3'd0) begin
                    acc_reg <= acc_sum;
                end
                if (tap_reg == 3'd3) begin
                    h2_reg <= hq;
                end
                if (tap_reg == 3'd5) begin
                    tap_reg  <= 3'd0;
                    base_reg <= base_reg + HAW'(4);
                    if (last_stage) begin
                        stage_reg <= '0;
                        ch_reg    <= 1'b1;
                        if (!ch_reg) begin
                            yi_reg    <= y_val;
                            x_cur_reg <= xq_reg;
                        end else begin
                            yq_reg <= y_val;
                        end
                    end else begin
                        stage_reg <= stage_reg + SW'(1);
                        x_cur_reg <= y_val;
                    end
                end else begin
                    tap_reg <= tap_reg + 3'd1;
                end
            end
            amf_pkg::ST_EN_Q: begin
                e_reg <= prod[63:33];
            end
            amf_pkg::ST_EN_SUM: begin
                e_reg <= e_reg + prod[63:33];
            end
            amf_pkg::ST_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= sq_root;
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/core/amf_checker.sv */
`include "assert_macros.svh"

module amf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // one item in flight: no new transaction right after one is taken
    `ASSERT_NXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a result never appears right after an input transaction
    `ASSERT_NXT(a_out_gap, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, !m_tvalid)
    // envelope never sets the pad bit
    `ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, !m_tdata[31])
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind am_iq_mix_filter_magnitude_unit amf_checker u_amf_checker (.*);
